// File: rtl/rbnb_pkg.sv
package rbnb_pkg;

    localparam int SLOTS       = 256;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int SEQ_W       = 16;
    localparam int HANDLE_W    = 16;
    localparam int BITMAP_BITS = 128;
    localparam int HALF_BITS   = BITMAP_BITS / 2;
    localparam int COUNT_W     = 9;
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int OCC_W       = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    typedef enum logic [1:0] {
        MODE_STORE  = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_LOOKUP = 2'd2,
        MODE_BITMAP = 2'd3
    } mode_t;

    typedef struct packed {
        logic capture;
        logic exec;
    } dp_cmd_t;

endpackage

// File: rtl/rbnb_ctrl.sv
module rbnb_ctrl
    import rbnb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    output logic    done,
    output dp_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = (state_reg == ST_RESP);
    assign cmd.capture = start && (state_reg == ST_IDLE);
    assign cmd.exec    = (state_reg == ST_EXEC);

endmodule

// File: rtl/rbnb_dp.sv
module rbnb_dp
    import rbnb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    input  logic [1:0]            mode,
    input  logic [SEQ_W-1:0]      seq_num,
    input  logic [HANDLE_W-1:0]   packet_handle,
    input  logic [SEQ_W-1:0]      base_seq,
    output logic                  slot_received,
    output logic [HANDLE_W-1:0]   handle_out,
    output logic [HALF_BITS-1:0]  bitmap_low,
    output logic [HALF_BITS-1:0]  bitmap_high,
    output logic [COUNT_W-1:0]    stored_count,
    output logic                  is_empty,
    output logic                  overwrite
);

    // captured transaction
    mode_t                  mode_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [HANDLE_W-1:0]    handle_reg;
    logic [SLOT_W-1:0]      start_reg;

    // slot state
    logic [SLOTS-1:0]       flags_reg;
    logic [SLOTS-1:0]       flags_next;
    logic [OCC_W-1:0]       occ_reg;
    logic [OCC_W-1:0]       occ_next;
    logic [HANDLE_W-1:0]    handle_mem [SLOTS];
    logic [HANDLE_W-1:0]    rdata_reg;

    // result
    logic                   rx_reg;
    logic                   rx_next;
    logic                   ovw_reg;
    logic                   ovw_next;
    logic [BITMAP_BITS-1:0] bitmap_reg;
    logic [BITMAP_BITS-1:0] bitmap_next;

    logic                   flag_cur;
    logic                   mem_we;
    logic                   mem_re;
    logic [BITMAP_BITS-1:0] flags_rot;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg   <= mode_t'(mode);
            slot_reg   <= seq_num[SLOT_W-1:0];
            handle_reg <= packet_handle;
            start_reg  <= base_seq[SLOT_W-1:0] + SLOT_W'(1);
        end
    end

    assign flag_cur  = flags_reg[slot_reg];
    assign flags_rot = BITMAP_BITS'({flags_reg, flags_reg} >> start_reg);

    always_comb
    begin
        flags_next  = flags_reg;
        occ_next    = occ_reg;
        rx_next     = 1'b0;
        ovw_next    = 1'b0;
        bitmap_next = '0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        if (cmd.exec)
        begin
            unique case (mode_reg)
                MODE_STORE:
                begin
                    mem_we = 1'b1;
                    if (flag_cur)
                    begin
                        ovw_next = 1'b1;
                    end
                    else
                    begin
                        flags_next[slot_reg] = 1'b1;
                        occ_next             = occ_reg + OCC_W'(1);
                    end
                end
                MODE_CLEAR:
                begin
                    if (flag_cur)
                    begin
                        flags_next[slot_reg] = 1'b0;
                        occ_next             = occ_reg - OCC_W'(1);
                    end
                end
                MODE_LOOKUP:
                begin
                    mem_re  = 1'b1;
                    rx_next = flag_cur;
                end
                MODE_BITMAP:
                begin
                    bitmap_next = flags_rot;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            occ_reg   <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rx_reg     <= rx_next;
            ovw_reg    <= ovw_next;
            bitmap_reg <= bitmap_next;
        end
    end

    // handle store, one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            handle_mem[slot_reg] <= handle_reg;
        end
        if (mem_re)
        begin
            rdata_reg <= handle_mem[slot_reg];
        end
    end

    assign slot_received = rx_reg;
    assign handle_out    = rx_reg ? rdata_reg : '0;
    assign bitmap_low    = bitmap_reg[HALF_BITS-1:0];
    assign bitmap_high   = bitmap_reg[BITMAP_BITS-1:HALF_BITS];
    assign stored_count  = occ_reg[COUNT_W-1:0];
    assign is_empty      = (occ_reg == '0);
    assign overwrite     = ovw_reg;

endmodule

// File: rtl/reorder_buffer_nack_bitmap_top.sv
// Receive reorder slot store with nack bitmap.
// Command channel: a transaction (mode, seq_num, packet_handle, base_seq)
// is taken at a rising edge with start high and busy low. Modes: store a
// handle, clear a slot, look a slot up, or build the 128-bit received
// bitmap for base_seq+1 .. base_seq+128.
// Result channel: done is high for exactly one cycle, in the respond state
// that follows the execute state; the result ports are valid in that cycle
// and hold afterwards. Transactions do not overlap: each runs capture,
// execute (flag update, handle memory access, bitmap rotate), respond. The
// lookup needs the registered read of the single-port handle memory, which
// sets this capture, execute, respond sequence.
// The bitmap is a rotate of the slot flag register by base_seq+1 and a
// select of its low 128 bits.
// Reset clears all slot flags and the occupancy count at once; the handle
// memory is not cleared and is only shown through a set flag. No clearing
// pass is needed, so start is taken in the first cycle after reset.
// The receiver cannot stall: done is never held off.
module reorder_buffer_nack_bitmap_top
    import rbnb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            mode,
    input  logic [SEQ_W-1:0]      seq_num,
    input  logic [HANDLE_W-1:0]   packet_handle,
    input  logic [SEQ_W-1:0]      base_seq,
    output logic                  done,
    output logic                  slot_received,
    output logic [HANDLE_W-1:0]   handle_out,
    output logic [HALF_BITS-1:0]  bitmap_low,
    output logic [HALF_BITS-1:0]  bitmap_high,
    output logic [COUNT_W-1:0]    stored_count,
    output logic                  is_empty,
    output logic                  overwrite
);

    dp_cmd_t cmd;

    rbnb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    rbnb_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .mode          (mode),
        .seq_num       (seq_num),
        .packet_handle (packet_handle),
        .base_seq      (base_seq),
        .slot_received (slot_received),
        .handle_out    (handle_out),
        .bitmap_low    (bitmap_low),
        .bitmap_high   (bitmap_high),
        .stored_count  (stored_count),
        .is_empty      (is_empty),
        .overwrite     (overwrite)
    );

endmodule

// File: rtl/rbnb_checker.sv
module rbnb_checker
    import rbnb_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic                  slot_received,
    input logic [HANDLE_W-1:0]   handle_out,
    input logic                  overwrite
);

    // accepted transaction holds the channel busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // done follows each accept through the execute state
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result not delivered two cycles after accept");

    // one strobe per transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    // overwrite and lookup hit come from different modes
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(overwrite && slot_received))
        else $error("overwrite and slot_received both set");

    // empty slot never shows a handle
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !slot_received) |-> (handle_out == '0))
        else $error("handle shown for empty slot");

endmodule

bind reorder_buffer_nack_bitmap_top rbnb_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .slot_received (slot_received),
    .handle_out    (handle_out),
    .overwrite     (overwrite)
);
